>>> src/csvmax_pkg.sv
package csvmax_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int COL_W       = 14;
  localparam int MAX_W       = 31;
  localparam int CPL_W       = 15;
  localparam int SKIP_W      = 2;
  localparam int ERR_W       = 2;
  localparam int MAG_W       = 32;
  localparam int MAG_EXT_W   = 36;
  localparam int COL_EXT_W   = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 80;

  localparam int MAX_COLUMNS_DEF = 16384;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_PER_LINE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_SKIP     = 1'd1;

  // Characters
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  localparam logic [MAG_EXT_W-1:0] MAG_LIMIT = 36'h0_8000_0000;
  localparam logic [MAG_W-1:0]     POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [COL_W-1:0]     COL_LIMIT = 14'h3FFF;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FIELD = 2'd1,
    ERR_SHORT = 2'd2,
    ERR_EXTRA = 2'd3
  } err_t;

  // One ended field, handed from the parser to the max-store stage
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   col;
    logic [MAX_W-1:0]   pos;
    logic               keep;
    logic               eol;
    err_t               err;
  } fld_t;

endpackage

>>> src/csv_decimal_row_parser_with_maxima_top.sv
// Path: a field goes from the stage 1 registers to the output register behind m_tvalid.
// Throughput: one text byte per cycle when not stalled; the column-maximum store is read at
//   accept, written back from stage 1, bypassed when the next field hits the same column.
// Reset: synchronous, active high. After reset the store is swept to zero, one entry a cycle,
//   over all MAX_COLUMNS entries; s_tready stays low during the sweep, cfg writes are taken.
module csv_decimal_row_parser_with_maxima_top import csvmax_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream; tdata: text_byte[7:0]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,
  // output stream; tdata: parsed_value[31:0], column_index[45:32],
  //   column_maximum[76:46], zero[79:77]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tlast,    // end_of_line
  output logic [ERR_W-1:0]       m_tuser,    // error_code[1:0]
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CPL_W-1:0]       cfg_data
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration registers
  logic [CPL_W-1:0]  columns_per_line;
  logic [SKIP_W-1:0] leading_fields_skipped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_per_line       <= 15'd1;
      leading_fields_skipped <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMNS_PER_LINE: columns_per_line       <= cfg_data;
        REG_LEADING_SKIP:     leading_fields_skipped <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Store clear sweep after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_COLUMNS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Handshake: stage 1 holds one field, the output register another
  logic accept, s1_valid, s1_adv, out_valid;

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Stage 0: byte parser
  fld_t fld;

  csvmax_parse u_parse (
    .clk                    (clk),
    .rst                    (rst),
    .take                   (accept),
    .text_byte              (s_tdata[BYTE_W-1:0]),
    .columns_per_line       (columns_per_line),
    .leading_fields_skipped (leading_fields_skipped),
    .fld                    (fld)
  );

  logic [COL_EXT_W-1:0] req_col_ext;
  logic                 req_in_range;
  logic [AW-1:0]        req_addr;

  assign req_col_ext  = {{(COL_EXT_W-COL_W){1'b0}}, fld.col};
  assign req_in_range = (req_col_ext < COL_EXT_W'(MAX_COLUMNS));
  assign req_addr     = req_col_ext[AW-1:0];

  // Stage 1 registers
  logic [VALUE_W-1:0] s1_value;
  logic [COL_W-1:0]   s1_col;
  logic [MAX_W-1:0]   s1_pos;
  logic [AW-1:0]      s1_addr;
  logic               s1_keep, s1_in_range, s1_eol;
  err_t               s1_err;

  // Column maximum store: one read port at accept, one write port in stage 1
  logic [MAX_W-1:0] store_mem [MAX_COLUMNS];
  logic [MAX_W-1:0] store_rd, fwd_val, s1_cur, s1_new;
  logic             fwd_hit;

  assign s1_cur = fwd_hit ? fwd_val : store_rd;
  assign s1_new = (s1_keep && (s1_pos > s1_cur)) ? s1_pos : s1_cur;

  always_ff @(posedge clk) begin
    if (accept) begin
      store_rd <= store_mem[req_addr];
      // write of the leaving field lands at this same edge: bypass it
      fwd_hit  <= s1_adv && s1_keep && (s1_addr == req_addr);
      fwd_val  <= s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      store_mem[clr_addr] <= '0;
    end else if (s1_adv && s1_keep) begin
      store_mem[s1_addr] <= s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= fld.hit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value    <= fld.value;
      s1_col      <= fld.col;
      s1_pos      <= fld.pos;
      s1_addr     <= req_addr;
      s1_keep     <= fld.keep && req_in_range;
      s1_in_range <= req_in_range;
      s1_eol      <= fld.eol;
      s1_err      <= fld.err;
    end
  end

  // Output register
  logic [VALUE_W-1:0] out_value;
  logic [COL_W-1:0]   out_col;
  logic [MAX_W-1:0]   out_max;
  logic               out_eol;
  err_t               out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value <= s1_value;
      out_col   <= s1_col;
      out_max   <= s1_in_range ? s1_new : '0;
      out_eol   <= s1_eol;
      out_err   <= s1_err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_OUT_W-VALUE_W-COL_W-MAX_W){1'b0}}, out_max, out_col, out_value};
  assign m_tlast  = out_eol;
  assign m_tuser  = out_err;

endmodule

>>> src/csvmax_parse.sv
module csvmax_parse import csvmax_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic [CPL_W-1:0]  columns_per_line,
  input  logic [SKIP_W-1:0] leading_fields_skipped,
  output fld_t              fld
);

  typedef enum logic [1:0] {
    PH_LINE_START = 2'd0,
    PH_SKIP       = 2'd1,
    PH_NUMBER     = 2'd2,
    PH_BAD        = 2'd3
  } phase_t;

  phase_t            phase, phase_next, eff_ph;
  logic [SKIP_W-1:0] skip_cnt, skip_cnt_next, eff_cnt, cnt_inc;
  logic [COL_W-1:0]  col, col_next, eff_col;
  logic [MAG_W-1:0]  mag, mag_next, eff_mag;
  logic              neg, neg_next, eff_neg;
  logic              dig, dig_next, eff_dig;
  logic              sgn, sgn_next, eff_sgn;

  logic                 is_brk, is_comma, is_digit, is_blank, is_sign, bad, hit;
  logic [MAG_EXT_W-1:0] mag_mul;
  logic [MAG_W-1:0]     pos_val;
  logic [CPL_W-1:0]     col_wide;

  assign is_brk   = (text_byte == CH_LF) || (text_byte == CH_CR);
  assign is_comma = (text_byte == CH_COMMA);
  assign is_digit = (text_byte >= CH_0) && (text_byte <= CH_9);
  assign is_blank = (text_byte == CH_SP) || (text_byte == CH_TAB) ||
                    (text_byte == CH_VT) || (text_byte == CH_FF);
  assign is_sign  = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);

  // x*10 + d as two shifted adds
  assign mag_mul = ({{(MAG_EXT_W-MAG_W){1'b0}}, eff_mag} << 3) +
                   ({{(MAG_EXT_W-MAG_W){1'b0}}, eff_mag} << 1) +
                   {{(MAG_EXT_W-4){1'b0}}, text_byte[3:0]};

  assign cnt_inc  = eff_cnt + 2'd1;
  assign col_wide = {1'b0, eff_col};
  assign bad      = (eff_ph == PH_BAD) || !eff_dig;
  assign pos_val  = (eff_mag > POS_LIMIT) ? POS_LIMIT : eff_mag;

  always_comb begin
    // a non-break byte at line start opens a new line
    eff_ph  = phase;
    eff_cnt = skip_cnt;
    eff_col = col;
    eff_mag = mag;
    eff_neg = neg;
    eff_dig = dig;
    eff_sgn = sgn;
    if (phase == PH_LINE_START && !is_brk) begin
      eff_cnt = '0;
      eff_col = '0;
      eff_mag = '0;
      eff_neg = 1'b0;
      eff_dig = 1'b0;
      eff_sgn = 1'b0;
      eff_ph  = (leading_fields_skipped != '0) ? PH_SKIP : PH_NUMBER;
    end
  end

  always_comb begin
    phase_next    = eff_ph;
    skip_cnt_next = eff_cnt;
    col_next      = eff_col;
    mag_next      = eff_mag;
    neg_next      = eff_neg;
    dig_next      = eff_dig;
    sgn_next      = eff_sgn;
    hit           = 1'b0;
    fld           = '0;
    case (eff_ph)
      PH_LINE_START: begin
        // line break run: nothing to do
      end
      PH_SKIP: begin
        if (is_brk) begin
          phase_next = PH_LINE_START;
          if (columns_per_line != '0) begin
            hit     = 1'b1;
            fld.eol = 1'b1;
            fld.err = ERR_SHORT;
          end
        end else if (is_comma) begin
          skip_cnt_next = cnt_inc;
          if (cnt_inc >= leading_fields_skipped) begin
            phase_next = PH_NUMBER;
            mag_next   = '0;
            neg_next   = 1'b0;
            dig_next   = 1'b0;
            sgn_next   = 1'b0;
          end
        end
      end
      PH_NUMBER, PH_BAD: begin
        if (is_comma || is_brk) begin
          hit       = 1'b1;
          fld.col   = eff_col;
          fld.eol   = is_brk;
          fld.pos   = (!bad && !eff_neg) ? pos_val[MAX_W-1:0] : '0;
          fld.value = bad ? '0 : (eff_neg ? (32'd0 - eff_mag) : pos_val);
          if (col_wide >= columns_per_line) begin
            fld.err = ERR_EXTRA;
          end else if (bad) begin
            fld.err = ERR_FIELD;
          end else if (is_brk && (col_wide + 15'd1 < columns_per_line)) begin
            fld.err = ERR_SHORT;
          end else begin
            fld.err = ERR_NONE;
          end
          fld.keep = (fld.err == ERR_NONE) || (fld.err == ERR_SHORT);
          if (is_brk) begin
            phase_next = PH_LINE_START;
          end else begin
            phase_next = PH_NUMBER;
            if (eff_col < COL_LIMIT) begin
              col_next = eff_col + 14'd1;
            end
          end
          mag_next = '0;
          neg_next = 1'b0;
          dig_next = 1'b0;
          sgn_next = 1'b0;
        end else if (eff_ph == PH_NUMBER) begin
          if (is_digit) begin
            mag_next = (mag_mul > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_mul[MAG_W-1:0];
            dig_next = 1'b1;
          end else if (!eff_dig && !eff_sgn && is_blank) begin
            // leading blank
          end else if (!eff_dig && !eff_sgn && is_sign) begin
            sgn_next = 1'b1;
            neg_next = (text_byte == CH_MINUS);
          end else begin
            phase_next = PH_BAD;
          end
        end
      end
      default: begin
        phase_next = PH_LINE_START;
      end
    endcase
    fld.hit = hit && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LINE_START;
      skip_cnt <= '0;
      col      <= '0;
      mag      <= '0;
      neg      <= 1'b0;
      dig      <= 1'b0;
      sgn      <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      skip_cnt <= skip_cnt_next;
      col      <= col_next;
      mag      <= mag_next;
      neg      <= neg_next;
      dig      <= dig_next;
      sgn      <= sgn_next;
    end
  end

endmodule

>>> src/csvmax_chk.sv
module csvmax_chk import csvmax_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic [ERR_W-1:0]       m_tuser
);

  // no input taken and no result shown right after reset (store sweep)
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("activity right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled result changed");

  // clean nonnegative value never exceeds its column maximum
  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ERR_NONE) && !m_tdata[31] |->
      m_tdata[76:46] >= m_tdata[30:0])
    else $error("column maximum below value");

  // malformed field reads as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ERR_FIELD) |-> m_tdata[31:0] == 32'd0)
    else $error("malformed field with nonzero value");

endmodule

bind csv_decimal_row_parser_with_maxima_top csvmax_chk u_csvmax_chk (.*);
